// ----- sv/ntcb_pkg.sv -----
package ntcb_pkg;

  localparam int DIV_NW = 41;
  localparam int DIV_QW = 37;
  localparam int DIV_DW = 38;

  localparam int LOG_STEPS = 16;
  localparam int MANT_W = 31;
  localparam int LOG_W = 21;

  localparam int CFG_W = 20;

  localparam logic [1:0] CFG_DIVIDER_OHM = 2'd0;
  localparam logic [1:0] CFG_SUPPLY_MV = 2'd1;
  localparam logic [1:0] CFG_NOMINAL_OHM = 2'd2;
  localparam logic [1:0] CFG_BETA_KELVIN = 2'd3;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [38:0] INV_T25_Q32 = 39'd14405391;
  localparam logic [39:0] HUNDRED_Q32 = 40'd429496729600;
  localparam logic [17:0] OFFSET_CENTI = 18'd27315;
  localparam logic [16:0] CK_MAX = 17'd60082;
  localparam logic [15:0] TEMP_MAX = 16'd32767;

  typedef enum logic [1:0] {
    ST_OK,
    ST_INVALID,
    ST_SAT
  } status_t;

  typedef struct packed {
    status_t status;
    logic    neg;
  } tag_t;

endpackage

// ----- sv/ntcb_div.sv -----
module ntcb_div import ntcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [DIV_NW-1:0] in_num,
  input  logic [DIV_DW-1:0] in_den,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [DIV_QW-1:0] out_quo,
  output tag_t              out_tag
);

  logic              valid_r [0:DIV_QW];
  logic [DIV_DW-1:0] rem_r   [0:DIV_QW];
  logic [DIV_QW-1:0] num_r   [0:DIV_QW];
  logic [DIV_QW-1:0] quo_r   [0:DIV_QW];
  logic [DIV_DW-1:0] den_r   [0:DIV_QW];
  tag_t              tag_r   [0:DIV_QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
    rem_r[0] <= DIV_DW'(in_num[DIV_NW-1:DIV_QW]);
    num_r[0] <= in_num[DIV_QW-1:0];
    quo_r[0] <= '0;
    den_r[0] <= in_den;
    tag_r[0] <= in_tag;
  end

  for (genvar s = 0; s < DIV_QW; s++) begin : g_step
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic [DIV_DW-1:0] rem_nxt;

    assign trial   = {rem_r[s], num_r[s][DIV_QW-1]};
    assign diff    = trial - {1'b0, den_r[s]};
    assign ge      = trial >= {1'b0, den_r[s]};
    assign rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= valid_r[s];
      end
      rem_r[s+1] <= rem_nxt;
      num_r[s+1] <= {num_r[s][DIV_QW-2:0], 1'b0};
      quo_r[s+1] <= {quo_r[s][DIV_QW-2:0], ge};
      den_r[s+1] <= den_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_valid = valid_r[DIV_QW];
  assign out_quo   = quo_r[DIV_QW];
  assign out_tag   = tag_r[DIV_QW];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && den_r[0] != '0 && rem_r[0] < den_r[0] |=> rem_r[1] < den_r[1])
    else $error("divider remainder not below divisor");

  a_den_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] |=> den_r[1] == $past(den_r[0]))
    else $error("divisor lost between stages");

  a_tag_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[DIV_QW-1] |=> out_tag == $past(tag_r[DIV_QW-1]) && out_valid)
    else $error("tag or valid lost at divider output");

endmodule

// ----- sv/ntcb_log2.sv -----
module ntcb_log2 import ntcb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [31:0]      in_a,
  input  logic [19:0]      in_b,
  input  tag_t             in_tag,
  output logic             out_valid,
  output logic [LOG_W-1:0] out_la,
  output logic [LOG_W-1:0] out_lb,
  output tag_t             out_tag
);

  logic [4:0]  ka;
  logic [4:0]  kb;
  logic [61:0] sha;
  logic [61:0] shb;

  always_comb begin
    ka = '0;
    kb = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_a[i]) ka = 5'(i);
    end
    for (int i = 0; i < 20; i++) begin
      if (in_b[i]) kb = 5'(i);
    end
    sha = {in_a, 30'b0} >> ka;
    shb = {12'b0, in_b, 30'b0} >> kb;
  end

  logic                 valid_r [0:LOG_STEPS];
  logic [MANT_W-1:0]    ma_r    [0:LOG_STEPS];
  logic [MANT_W-1:0]    mb_r    [0:LOG_STEPS];
  logic [LOG_STEPS-1:0] fa_r    [0:LOG_STEPS];
  logic [LOG_STEPS-1:0] fb_r    [0:LOG_STEPS];
  logic [4:0]           ka_r    [0:LOG_STEPS];
  logic [4:0]           kb_r    [0:LOG_STEPS];
  tag_t                 tag_r   [0:LOG_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
    ma_r[0]  <= sha[MANT_W-1:0];
    mb_r[0]  <= shb[MANT_W-1:0];
    fa_r[0]  <= '0;
    fb_r[0]  <= '0;
    ka_r[0]  <= ka;
    kb_r[0]  <= kb;
    tag_r[0] <= in_tag;
  end

  for (genvar s = 0; s < LOG_STEPS; s++) begin : g_sq
    logic [61:0]       sqa;
    logic [61:0]       sqb;
    logic [31:0]       qa;
    logic [31:0]       qb;
    logic [MANT_W-1:0] ma_nxt;
    logic [MANT_W-1:0] mb_nxt;

    assign sqa    = {31'b0, ma_r[s]} * {31'b0, ma_r[s]};
    assign sqb    = {31'b0, mb_r[s]} * {31'b0, mb_r[s]};
    assign qa     = sqa[61:30];
    assign qb     = sqb[61:30];
    assign ma_nxt = qa[31] ? qa[31:1] : qa[30:0];
    assign mb_nxt = qb[31] ? qb[31:1] : qb[30:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= valid_r[s];
      end
      ma_r[s+1]  <= ma_nxt;
      mb_r[s+1]  <= mb_nxt;
      fa_r[s+1]  <= {fa_r[s][LOG_STEPS-2:0], qa[31]};
      fb_r[s+1]  <= {fb_r[s][LOG_STEPS-2:0], qb[31]};
      ka_r[s+1]  <= ka_r[s];
      kb_r[s+1]  <= kb_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_valid = valid_r[LOG_STEPS];
  assign out_la    = {ka_r[LOG_STEPS], fa_r[LOG_STEPS]};
  assign out_lb    = {kb_r[LOG_STEPS], fb_r[LOG_STEPS]};
  assign out_tag   = tag_r[LOG_STEPS];

  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && ma_r[0][MANT_W-1] |=> ma_r[1][MANT_W-1])
    else $error("mantissa left normal range");

  a_nominal_norm: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && in_b != '0 |=> mb_r[0][MANT_W-1])
    else $error("nominal mantissa not normalized");

  a_int_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[LOG_STEPS-1] |=> ka_r[LOG_STEPS] == $past(ka_r[LOG_STEPS-1]))
    else $error("integer part of log lost");

endmodule

// ----- sv/ntc_beta_temperature.sv -----
// Channel   Ports                                   Handshake
// input     in_voltage_mv                           start && !busy
// result    out_temp_centi_c, out_status            out_valid, one cycle
// config    cfg_index, cfg_wdata                    cfg_we
//
// One beat enters per clock; busy stays low. Each result passes through
// three 37-step divider pipelines (resistance, log over Beta, reciprocal)
// and the 16 squaring stages of the log unit.
// Synchronous active-low reset clears the valid bits and loads the
// register defaults. The receiver cannot stall; the pipeline always advances.
module ntc_beta_temperature import ntcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [11:0]       in_voltage_mv,
  output logic              out_valid,
  output logic signed [15:0] out_temp_centi_c,
  output logic [1:0]        out_status,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic [19:0] div_ohm_r;
  logic [12:0] supply_r;
  logic [19:0] nominal_r;
  logic [13:0] beta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_ohm_r <= 20'd10000;
      supply_r  <= 13'd3300;
      nominal_r <= 20'd10000;
      beta_r    <= 14'd3950;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIVIDER_OHM: div_ohm_r <= cfg_wdata[19:0];
        CFG_SUPPLY_MV:   supply_r  <= cfg_wdata[12:0];
        CFG_NOMINAL_OHM: nominal_r <= cfg_wdata[19:0];
        CFG_BETA_KELVIN: beta_r    <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage
  logic        a_valid_r;
  logic [11:0] a_v_r;
  status_t     a_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start && !busy;
    end
    a_v_r      <= in_voltage_mv;
    a_status_r <= (in_voltage_mv == '0 || {1'b0, in_voltage_mv} >= supply_r) ?
                  ST_INVALID : ST_OK;
  end

  logic [31:0] a_num;
  logic [12:0] a_den;
  tag_t        a_tag;

  assign a_num = {12'b0, div_ohm_r} * {20'b0, a_v_r};
  assign a_den = supply_r - {1'b0, a_v_r};
  assign a_tag = '{status: a_status_r, neg: 1'b0};

  logic              d1_valid;
  logic [DIV_QW-1:0] d1_quo;
  tag_t              d1_tag;

  ntcb_div u_div_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid_r),
    .in_num    (DIV_NW'(a_num)),
    .in_den    (DIV_DW'(a_den)),
    .in_tag    (a_tag),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_tag   (d1_tag)
  );

  logic [31:0] res;
  logic [19:0] nom_eff;
  logic [13:0] beta_eff;
  tag_t        l_in_tag;

  assign res      = d1_quo[31:0];
  assign nom_eff  = (nominal_r == '0) ? 20'd1 : nominal_r;
  assign beta_eff = (beta_r == '0) ? 14'd1 : beta_r;

  always_comb begin
    l_in_tag = d1_tag;
    if (d1_tag.status == ST_OK && res == '0) l_in_tag.status = ST_SAT;
  end

  logic             l_valid;
  logic [LOG_W-1:0] l_la;
  logic [LOG_W-1:0] l_lb;
  tag_t             l_tag;

  ntcb_log2 u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d1_valid),
    .in_a      (res),
    .in_b      (nom_eff),
    .in_tag    (l_in_tag),
    .out_valid (l_valid),
    .out_la    (l_la),
    .out_lb    (l_lb),
    .out_tag   (l_tag)
  );

  // log difference
  logic             b_valid_r;
  logic [LOG_W-1:0] b_mag_r;
  tag_t             b_tag_r;
  tag_t             b_tag_nxt;

  always_comb begin
    b_tag_nxt     = l_tag;
    b_tag_nxt.neg = l_la < l_lb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= l_valid;
    end
    b_mag_r <= (l_la < l_lb) ? (l_lb - l_la) : (l_la - l_lb);
    b_tag_r <= b_tag_nxt;
  end

  // ln2 scaling in two partial products
  logic        c_valid_r;
  logic [36:0] c_phi_r;
  logic [36:0] c_plo_r;
  tag_t        c_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_phi_r <= {16'b0, b_mag_r} * {21'b0, LN2_Q32[31:16]};
    c_plo_r <= {16'b0, b_mag_r} * {21'b0, LN2_Q32[15:0]};
    c_tag_r <= b_tag_r;
  end

  logic [52:0] ln_sum;

  assign ln_sum = {c_phi_r, 16'b0} + {16'b0, c_plo_r} + 53'd32768;

  logic              d2_valid;
  logic [DIV_QW-1:0] d2_quo;
  tag_t              d2_tag;

  ntcb_div u_div_beta (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid_r),
    .in_num    (DIV_NW'(ln_sum[52:16])),
    .in_den    (DIV_DW'(beta_eff)),
    .in_tag    (c_tag_r),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_tag   (d2_tag)
  );

  // reciprocal temperature
  logic        e_valid_r;
  logic [38:0] e_x_r;
  tag_t        e_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else begin
      e_valid_r <= d2_valid;
    end
    e_x_r   <= d2_tag.neg ? (INV_T25_Q32 - {2'b0, d2_quo}) : (INV_T25_Q32 + {2'b0, d2_quo});
    e_tag_r <= d2_tag;
  end

  logic        f_valid_r;
  logic [37:0] f_x_r;
  logic [39:0] f_n_r;
  tag_t        f_tag_r;
  tag_t        f_tag_nxt;

  always_comb begin
    f_tag_nxt = e_tag_r;
    if (e_tag_r.status == ST_OK && (e_x_r[38] || e_x_r == '0)) f_tag_nxt.status = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= e_valid_r;
    end
    f_x_r   <= e_x_r[37:0];
    f_n_r   <= HUNDRED_Q32 + {3'b0, e_x_r[37:1]};
    f_tag_r <= f_tag_nxt;
  end

  tag_t f_out_tag;

  always_comb begin
    f_out_tag = f_tag_r;
    if (f_tag_r.status == ST_OK && {15'b0, f_n_r} >= {f_x_r, 17'b0}) f_out_tag.status = ST_SAT;
  end

  logic              d3_valid;
  logic [DIV_QW-1:0] d3_quo;
  tag_t              d3_tag;

  ntcb_div u_div_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid_r),
    .in_num    (DIV_NW'(f_n_r)),
    .in_den    (f_x_r),
    .in_tag    (f_out_tag),
    .out_valid (d3_valid),
    .out_quo   (d3_quo),
    .out_tag   (d3_tag)
  );

  // result stage
  logic [16:0] ck;
  logic [17:0] celsius;

  assign ck      = d3_quo[16:0];
  assign celsius = {1'b0, ck} - OFFSET_CENTI;

  logic        out_valid_r;
  logic [15:0] out_temp_r;
  status_t     out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d3_valid;
    end
    if (d3_tag.status == ST_INVALID) begin
      out_temp_r   <= '0;
      out_status_r <= ST_INVALID;
    end else if (d3_tag.status != ST_OK || ck > CK_MAX) begin
      out_temp_r   <= TEMP_MAX;
      out_status_r <= ST_SAT;
    end else begin
      out_temp_r   <= celsius[15:0];
      out_status_r <= ST_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_centi_c = out_temp_r;
  assign out_status       = out_status_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INVALID |-> out_temp_centi_c == 16'sd0)
    else $error("invalid status with nonzero temperature");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |-> out_temp_centi_c == 16'sd32767)
    else $error("saturated status without top value");

  a_ok_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_temp_centi_c >= -16'sd27315)
    else $error("temperature below absolute zero");

endmodule
